>>> design/vn3_pkg.sv
`default_nettype none
package vn3_pkg;
    localparam int FracBits = 16;
    localparam int Depth = 14;
    localparam logic [31:0] HashInit = 32'ha511e9b3;
    localparam logic [31:0] HashGold = 32'h9e3779b9;
    localparam logic [31:0] HashMul1 = 32'h7feb352d;
    localparam logic [31:0] HashMul2 = 32'h846ca68b;

    function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [31:0] v);
        logic [31:0] m;
        begin
            m = h ^ (v + HashGold + {h[25:0], 6'd0} + {2'd0, h[31:2]});
            hash_mix = m ^ {16'd0, m[31:16]};
        end
    endfunction

    function automatic logic signed [25:0] blend(input logic signed [24:0] a,
                                                 input logic signed [24:0] b,
                                                 input logic [15:0] s);
        logic signed [25:0] d;
        logic signed [42:0] p;
        begin
            d = 26'(b) - 26'(a);
            p = 43'(d) * $signed({1'b0, s});
            blend = 26'(a) + 26'(p >>> 16);
        end
    endfunction
endpackage
`default_nettype wire

>>> design/vn3_hash.sv
`default_nettype none
// one corner hash over ten stages, two multiplies per mix round
module vn3_hash import vn3_pkg::*; (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] cx,
    input  wire logic [31:0] cy,
    input  wire logic [31:0] cz,
    output logic [23:0]      corner
);
    logic [31:0] h_reg [0:9];
    logic [31:0] y_reg [0:2];
    logic [31:0] z_reg [0:5];
    logic [31:0] a_next [0:2];
    logic [31:0] b_next [0:2];
    logic [31:0] c_next [0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            b_next[r] = h_reg[3*r+1] ^ {15'd0, h_reg[3*r+1][31:15]};
            c_next[r] = h_reg[3*r+2] ^ {16'd0, h_reg[3*r+2][31:16]};
        end
        a_next[0] = hash_mix(seed ^ HashInit, cx);
        a_next[1] = hash_mix(c_next[0], y_reg[2]);
        a_next[2] = hash_mix(c_next[1], z_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg[0] <= a_next[0];
            y_reg[0] <= cy;
            z_reg[0] <= cz;
            for (int k = 1; k < 3; k++)
                y_reg[k] <= y_reg[k-1];
            for (int k = 1; k < 6; k++)
                z_reg[k] <= z_reg[k-1];
            for (int r = 0; r < 3; r++)
            begin
                h_reg[3*r+1] <= 32'(h_reg[3*r] * HashMul1);
                h_reg[3*r+2] <= 32'(b_next[r] * HashMul2);
            end
            h_reg[3] <= a_next[1];
            h_reg[6] <= a_next[2];
            h_reg[9] <= c_next[2];
        end
    end

    assign corner = h_reg[9][23:0];
endmodule
`default_nettype wire

>>> design/value_noise_3d.sv
`default_nettype none
// channel   | valid       | stall       | payload
// in        | in_valid    | in_stall    | coord_x, coord_y, coord_z
// out       | out_valid   | out_stall   | noise_value
// cfg       | cfg_we      | -           | cfg_data (noise_seed)
// one point per cycle while out is not stalled, through a 14-stage pipeline
// the corner hash chain (three mix rounds, two multiplies each) sets the depth
// reset clears the seed and all valid bits
// a stall on out freezes the whole pipeline only when the final stage holds data;
// in_stall follows out_stall in just that case
module value_noise_3d import vn3_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      noise_value
);
    logic [31:0] seed_reg;
    logic [Depth-1:0] v_reg;
    logic en;
    logic [31:0] c0 [0:2];
    logic [15:0] fr [0:2];
    logic [31:0] q_reg [0:2];
    logic [15:0] f_reg [0:2];
    logic [15:0] s_reg [0:2];
    logic [15:0] sd_reg [0:2][0:8];
    logic [31:0] cell_reg [0:2];
    logic [23:0] corner [0:7];
    logic signed [24:0] x_reg [0:3];
    logic signed [24:0] y_reg [0:1];
    logic signed [24:0] z_reg;
    logic [15:0] sy_reg, sz1_reg, sz2_reg;

    assign en = !(out_stall && v_reg[Depth-1]);
    assign in_stall = !en;
    assign out_valid = v_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_data;
            if (en)
                v_reg <= {v_reg[Depth-2:0], in_valid};
        end
    end

    always_comb
    begin
        c0[0] = coord_x; c0[1] = coord_y; c0[2] = coord_z;
        for (int a = 0; a < 3; a++)
            fr[a] = c0[a][FracBits-1:0];
    end

    // stage 0: cell and f*f; stage 1: smoothstep weight
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= 32'($signed(c0[a]) >>> FracBits);
                f_reg[a] <= fr[a];
                q_reg[a] <= 32'(fr[a]) * 32'(fr[a]);
                s_reg[a] <= 16'((33'(q_reg[a][31:16]) *
                                 (33'd196608 - 33'({f_reg[a], 1'b0}))) >> 16);
                sd_reg[a][0] <= s_reg[a];
                for (int k = 1; k < 9; k++)
                    sd_reg[a][k] <= sd_reg[a][k-1];
            end
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_corner
        vn3_hash u_hash (
            .clk(clk), .en(en), .seed(seed_reg),
            .cx(cell_reg[0] + 32'(g & 1)),
            .cy(cell_reg[1] + 32'((g >> 1) & 1)),
            .cz(cell_reg[2] + 32'((g >> 2) & 1)),
            .corner(corner[g])
        );
    end

    // hashes done at stage 10, weights sit in sd_reg[*][8]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                x_reg[k] <= 25'(blend({1'b0, corner[2*k]}, {1'b0, corner[2*k+1]},
                                      sd_reg[0][8]));
            sy_reg <= sd_reg[1][8];
            sz1_reg <= sd_reg[2][8];
            for (int k = 0; k < 2; k++)
                y_reg[k] <= 25'(blend(x_reg[2*k], x_reg[2*k+1], sy_reg));
            sz2_reg <= sz1_reg;
            z_reg <= 25'(blend(y_reg[0], y_reg[1], sz2_reg));
        end
    end

    assign noise_value = z_reg[23:0];

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid;
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result lost under stall");

    property p_no_stall_empty;
        @(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall;
    endproperty
    a_no_stall_empty: assert property (p_no_stall_empty) else $error("stall with empty output");

    property p_count;
        @(posedge clk) disable iff (!rst_n) en |=> v_reg[0] == $past(in_valid);
    endproperty
    a_count: assert property (p_count) else $error("valid bit lost at entry");
endmodule
`default_nettype wire

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    class noise_board;
        logic [23:0] pending[$];
        logic [31:0] seed;
        int          mismatches;
        int          checked;

        function new();
            seed = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [31:0] mix_round(logic [31:0] h, logic [31:0] v);
            logic [31:0] m;
            m = h ^ (v + 32'h9e3779b9 + (h << 6) + (h >> 2));
            m = m ^ (m >> 16);
            m = m * 32'h7feb352d;
            m = m ^ (m >> 15);
            m = m * 32'h846ca68b;
            m = m ^ (m >> 16);
            return m;
        endfunction

        function longint corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
            logic [31:0] h;
            h = seed ^ 32'ha511e9b3;
            h = mix_round(h, cx);
            h = mix_round(h, cy);
            h = mix_round(h, cz);
            return longint'(h[23:0]);
        endfunction

        function longint smooth(logic [31:0] v);
            longint f;
            longint q;
            longint t;
            f = longint'(v[15:0]);
            q = (f * f) >>> 16;
            t = 196608 - 2 * f;
            q = (q * t) >>> 16;
            if (q > 65535)
                q = 65535;
            return q;
        endfunction

        function longint lerp(longint a, longint b, longint s);
            return a + (((b - a) * s) >>> 16);
        endfunction

        function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            logic [31:0] x0, y0, z0, x1, y1, z1;
            longint      sx, sy, sz, lo, hi, r;
            x0 = $signed(px) >>> 16;
            y0 = $signed(py) >>> 16;
            z0 = $signed(pz) >>> 16;
            x1 = x0 + 1;
            y1 = y0 + 1;
            z1 = z0 + 1;
            sx = smooth(px);
            sy = smooth(py);
            sz = smooth(pz);
            lo = lerp(lerp(corner(x0, y0, z0), corner(x1, y0, z0), sx),
                      lerp(corner(x0, y1, z0), corner(x1, y1, z0), sx), sy);
            hi = lerp(lerp(corner(x0, y0, z1), corner(x1, y0, z1), sx),
                      lerp(corner(x0, y1, z1), corner(x1, y1, z1), sx), sy);
            r = lerp(lo, hi, sz);
            if (r < 0)
                r = 0;
            if (r > 24'hffffff)
                r = 24'hffffff;
            pending.insert(pending.size(), r[23:0]);
        endfunction

        function void check_noise(logic [23:0] got);
            logic [23:0] want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: noise_value=%h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("noise_value mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        noise_value;

    noise_board board;
    int         idle_pct;
    int         stall_pct;
    bit         hold_off;
    int         sent;
    longint     cycles;

    value_noise_3d u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL value_noise_3d");
            $finish;
        end
    end

    // result side: check on transfer, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_noise(noise_value);
            out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    function logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
            2: return {16'($urandom_range(7)) - 16'd4, 16'($urandom())};
            default: return {16'($urandom()), 16'($urandom_range(3) * 16'h4000)};
        endcase
    endfunction

    task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        coord_x <= px;
        coord_y <= py;
        coord_z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_point(px, py, pz);
        sent++;
    endtask

    task drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task write_seed(logic [31:0] value);
        cfg_we <= 1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        board.seed = value;
    endtask

    task random_points(int count);
        repeat (count)
            send_point(pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        logic [31:0] edges[6];
        board = new();
        edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                  32'h0000ffff, 32'h00010000};
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        in_valid = 0;
        coord_x = 0;
        coord_y = 0;
        coord_z = 0;
        out_stall = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        sent = 0;
        cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: seed at reset, lattice edges and wraparound
        foreach (edges[i])
            send_point(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h00008000, 32'hffff8000, 32'h12345678);
        drain();

        write_seed(32'hffffffff);
        foreach (edges[i])
            send_point(edges[i], edges[(i + 2) % 6], edges[(i + 5) % 6]);
        drain();

        write_seed($urandom());
        random_points(250);
        drain();

        idle_pct = 61;
        write_seed(32'h0);
        random_points(250);
        drain();

        idle_pct = 0;
        stall_pct = 61;
        write_seed($urandom());
        fork
            random_points(250);
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();

        idle_pct = 19;
        stall_pct = 19;
        write_seed(32'ha511e9b3);
        random_points(250);
        drain();

        $display("sent %0d points over six seeds, checked %0d results", sent, board.checked);
        $display("covered lattice wrap, seed extremes, idle and stall mixes, long hold-off");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS value_noise_3d");
        else
            $display("FAIL value_noise_3d");
        $finish;
    end
endmodule
